// ----- hw/rtl/hcd_pkg.sv -----
// Shared types and constants for the chunked transfer decoder.
package hcd_pkg;

  localparam int LEN_W  = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // classified input word
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] digit;
  } cls_t;

  // result word
  typedef struct packed {
    logic [7:0]       data;
    logic [1:0]       kind;
    logic [LEN_W-1:0] count;
  } res_t;

endpackage

// ----- hw/rtl/hcd_front.sv -----
// Front end: takes raw bytes and tags them with their character class.
module hcd_front (
  input  logic         in_push,
  input  logic [7:0]   in_byte,
  input  logic         in_message_start,
  output logic         in_full,
  input  logic         q_full,
  output logic         q_push,
  output hcd_pkg::cls_t q_wdata
);

  logic is_num, is_upper, is_lower;

  always_comb begin
    is_num   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    is_upper = (in_byte >= 8'h41) && (in_byte <= 8'h46);
    is_lower = (in_byte >= 8'h61) && (in_byte <= 8'h66);

    q_wdata.data   = in_byte;
    q_wdata.start  = in_message_start;
    q_wdata.is_cr  = (in_byte == hcd_pkg::CHAR_CR);
    q_wdata.is_lf  = (in_byte == hcd_pkg::CHAR_LF);
    q_wdata.is_hex = is_num || is_upper || is_lower;
    if (is_num) begin
      q_wdata.digit = in_byte[3:0];
    end else if (is_upper || is_lower) begin
      q_wdata.digit = in_byte[3:0] + 4'd9;
    end else begin
      q_wdata.digit = 4'd0;
    end
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

endmodule

// ----- hw/rtl/hcd_cls_fifo.sv -----
// Short queue of classified words between front and back.
module hcd_cls_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hcd_pkg::cls_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output hcd_pkg::cls_t rdata
);

  hcd_pkg::cls_t                  mem_r [hcd_pkg::QDEPTH];
  logic [hcd_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [hcd_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full    = (cnt_r == hcd_pkg::QCNT_W'(hcd_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/hcd_back.sv -----
// Back end: chunk parser state machine and result queue.
module hcd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  hcd_pkg::cls_t             q_rdata,
  output logic                      q_pop,
  input  logic                      cfg_valid,
  input  logic [hcd_pkg::LEN_W-1:0] cfg_max_output_len,
  output logic                      out_empty,
  input  logic                      out_pop,
  output hcd_pkg::res_t             out_res
);

  localparam int W = hcd_pkg::LEN_W;

  typedef enum logic [2:0] {
    PH_SIZE, PH_SIZE_LF, PH_DATA, PH_DATA_CR, PH_DATA_LF, PH_DONE
  } phase_t;

  phase_t                     phase_r, phase_nxt, eff_phase;
  logic [W-1:0]               rem_r, rem_nxt, eff_rem;
  logic                       seen_r, seen_nxt, eff_seen;
  logic [W-1:0]               bytes_r, bytes_nxt, eff_bytes;
  logic [W-1:0]               max_r;
  logic [W-1:0]               rem_dec, bytes_inc;
  hcd_pkg::res_t              res;
  logic                       emit;

  hcd_pkg::res_t              oq_r [hcd_pkg::QDEPTH];
  logic [hcd_pkg::QPTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [hcd_pkg::QCNT_W-1:0] oq_cnt_r;
  logic                       take, oq_push, oq_pop;

  // take a word only when the result queue has a free slot
  assign take    = !q_empty && (oq_cnt_r != hcd_pkg::QCNT_W'(hcd_pkg::QDEPTH));
  assign q_pop   = take;
  assign oq_push = take && emit;
  assign oq_pop  = out_pop && (oq_cnt_r != '0);
  assign out_empty = (oq_cnt_r == '0);
  assign out_res   = oq_r[oq_rd_r];

  always_comb begin
    // message_start clears the parser before the byte is handled
    eff_phase = q_rdata.start ? PH_SIZE : phase_r;
    eff_rem   = q_rdata.start ? '0 : rem_r;
    eff_seen  = q_rdata.start ? 1'b0 : seen_r;
    eff_bytes = q_rdata.start ? '0 : bytes_r;

    rem_dec   = eff_rem - 1'b1;
    bytes_inc = eff_bytes + 1'b1;

    phase_nxt = eff_phase;
    rem_nxt   = eff_rem;
    seen_nxt  = eff_seen;
    bytes_nxt = eff_bytes;
    emit      = 1'b0;
    res.data  = 8'd0;
    res.kind  = hcd_pkg::KIND_ERROR;
    res.count = eff_bytes;

    unique case (eff_phase)
      PH_SIZE: begin
        if (q_rdata.is_cr) begin
          if (!eff_seen) begin
            emit = 1'b1;
          end else begin
            phase_nxt = PH_SIZE_LF;
          end
        end else if (!q_rdata.is_hex || (|eff_rem[W-1:W-4])) begin
          emit = 1'b1;
        end else begin
          rem_nxt  = {eff_rem[W-5:0], q_rdata.digit};
          seen_nxt = 1'b1;
        end
      end
      PH_SIZE_LF: begin
        if (!q_rdata.is_lf) begin
          emit = 1'b1;
        end else if (eff_rem == '0) begin
          phase_nxt = PH_DONE;
          emit      = 1'b1;
          res.kind  = hcd_pkg::KIND_END;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        emit = 1'b1;
        if (!((eff_bytes >= max_r) || (&eff_bytes))) begin
          bytes_nxt = bytes_inc;
          rem_nxt   = rem_dec;
          if (rem_dec == '0) phase_nxt = PH_DATA_CR;
          res.data  = q_rdata.data;
          res.kind  = hcd_pkg::KIND_DATA;
          res.count = bytes_inc;
        end
      end
      PH_DATA_CR: begin
        if (!q_rdata.is_cr) begin
          emit = 1'b1;
        end else begin
          phase_nxt = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (!q_rdata.is_lf) begin
          emit = 1'b1;
        end else begin
          phase_nxt = PH_SIZE;
          rem_nxt   = '0;
          seen_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // every error parks the parser until the next message
    if (emit && res.kind == hcd_pkg::KIND_ERROR) phase_nxt = PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIZE;
      rem_r    <= '0;
      seen_r   <= 1'b0;
      bytes_r  <= '0;
      max_r    <= '1;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (cfg_valid) max_r <= cfg_max_output_len;
      if (take) begin
        phase_r <= phase_nxt;
        rem_r   <= rem_nxt;
        seen_r  <= seen_nxt;
        bytes_r <= bytes_nxt;
      end
      if (oq_push) oq_wr_r <= oq_wr_r + 1'b1;
      if (oq_pop)  oq_rd_r <= oq_rd_r + 1'b1;
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/http_chunked_decoder.sv -----
// Top level of the HTTP chunked transfer decoder.
// Decodes a chunked HTTP body one byte per word: hex size lines ended by CR LF, then that many
// payload bytes, then CR LF. Each input word yields zero or one result word (payload byte, end of
// message on a zero size, or one error, after which bytes are dropped until in_message_start).
// A word is accepted every cycle while in_full is low; it passes a four-entry queue of classified
// bytes, is parsed by the back end and is written into the result queue, from which it shows
// on the out_ side and can be popped. Sustained rate is one byte per cycle while the result
// queue does not fill; that four-entry queue lets the output stall without stopping the input
// until both queues fill. cfg_ready is always high; write the payload limit only while idle.
module http_chunked_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [7:0]                in_byte,
  input  logic                      in_message_start,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [7:0]                out_byte,
  output logic [1:0]                out_result_kind,
  output logic [hcd_pkg::LEN_W-1:0] out_payload_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hcd_pkg::LEN_W-1:0] cfg_max_output_len
);

  hcd_pkg::cls_t q_wdata, q_rdata;
  hcd_pkg::res_t out_res;
  logic          q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  hcd_front u_front (
    .in_push          (in_push),
    .in_byte          (in_byte),
    .in_message_start (in_message_start),
    .in_full          (in_full),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  hcd_cls_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  hcd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_max_output_len (cfg_max_output_len),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_res            (out_res)
  );

  assign out_byte          = out_res.data;
  assign out_result_kind   = out_res.kind;
  assign out_payload_count = out_res.count;

  // a payload byte always counts itself
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind == hcd_pkg::KIND_DATA) |-> out_payload_count != '0)
    else $error("payload result with zero count");

  // end and error results carry no byte
  a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind != hcd_pkg::KIND_DATA) |-> out_byte == 8'd0)
    else $error("control result with nonzero byte");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_result_kind != hcd_pkg::KIND_NONE)
    else $error("illegal result kind");

  // a queued word is drained whenever the back end has room
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && out_empty) |-> q_pop)
    else $error("back end stalled with empty result queue");

endmodule
